/* hw/rtl/tse_pkg.sv */
`default_nettype none

package tse_pkg;

    localparam int LABEL_BITS = 8;
    localparam int NUM_LABELS = 1 << LABEL_BITS;
    localparam int MAX_EDGES  = 256;
    localparam int EDGE_IDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EDGE_CNT_W = $clog2(MAX_EDGES + 1);
    localparam int DEG_W      = 9;

    typedef logic [LABEL_BITS-1:0] t_label;
    typedef logic [DEG_W-1:0]      t_deg;

    localparam t_deg DEG_MAX = '1;

    localparam logic [1:0] ACT_ADD_VERTEX = 2'd0;
    localparam logic [1:0] ACT_ADD_EDGE   = 2'd1;
    localparam logic [1:0] ACT_NEXT       = 2'd2;
    localparam logic [1:0] ACT_CLEAR      = 2'd3;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] vertex_label;
        logic [7:0] edge_from;
        logic [7:0] edge_to;
    } t_in_word;

    typedef struct packed {
        logic [7:0] source_label;
        logic       found;
        logic       edge_overflow;
    } t_out_word;

    typedef struct packed {
        t_deg deg;
        logic present;
        logic finished;
    } t_lentry;

    typedef struct packed {
        t_label from_lbl;
        t_label to_lbl;
    } t_edge;

endpackage

`default_nettype wire

/* hw/rtl/topological_sort_engine.sv */
`default_nettype none

// Kahn topological sort engine.
// Command channel: a word on i_cmd is taken on a clock edge with start high
// and busy low. Add-vertex and a stored add-edge pass through a label write
// state; clear and an add-edge dropped on a full edge store are done in the
// idle state; none of them returns a word. Next-in-order returns one word
// on o_result, marked by o_strobe for one cycle, after a scan of the label
// memory (one label per cycle, ending at the first source found) and, when a
// source other than label 0 is found, one pass over the edge memory (one
// stored edge per cycle). The read, modify and write of the label memory,
// whose read is registered, sets the pace.
// busy stays high until the result word is shown, so one command is in
// flight at a time.
// Reset and clear empty all tables at once through per-label valid bits
// and the edge fill count; no sweep is needed.
// The receiver cannot stall: each result word is valid for exactly the
// strobe cycle.
module topological_sort_engine
    import tse_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    input  wire t_in_word  i_cmd,
    output logic           busy,
    output logic           o_strobe,
    output t_out_word      o_result
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LBL_WR = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_EDGE   = 2'd3;

    t_lentry lbl_mem [NUM_LABELS];
    t_edge   edge_mem [MAX_EDGES];

    logic [1:0]            r_state, n_state;
    logic                  r_is_edge, n_is_edge;
    t_label                r_lbl_addr;
    t_label                r_scan_cnt, n_scan_cnt;
    logic                  r_chk_vld, n_chk_vld;
    t_label                r_pick, n_pick;
    logic [EDGE_CNT_W-1:0] r_eidx, n_eidx;
    logic                  r_eb_vld, n_eb_vld;
    logic                  r_ec_vld, n_ec_vld;
    logic [EDGE_CNT_W-1:0] r_edge_total, n_edge_total;
    logic                  r_overflow, n_overflow;
    logic [NUM_LABELS-1:0] r_valid;
    logic                  r_fwd_vld;
    t_label                r_fwd_addr;
    t_lentry               r_fwd_data;
    logic                  r_strobe, n_strobe;
    t_out_word             r_result, n_result;

    logic                  accept;
    logic                  do_clear;
    t_label                lbl_raddr;
    t_lentry               lbl_rdata;
    logic                  lbl_we;
    t_label                lbl_waddr;
    t_lentry               lbl_wdata;
    t_lentry               entry_cur;
    logic [EDGE_IDX_W-1:0] edge_raddr;
    t_edge                 edge_rdata;
    logic                  edge_we;
    t_edge                 edge_wdata;
    logic                  edge_more;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    always_comb begin
        if (r_fwd_vld && (r_fwd_addr == r_lbl_addr)) begin
            entry_cur = r_fwd_data;
        end else if (r_valid[r_lbl_addr]) begin
            entry_cur = lbl_rdata;
        end else begin
            entry_cur = '0;
        end
    end

    assign edge_more = (r_eidx < r_edge_total);

    always_comb begin
        n_state      = r_state;
        n_is_edge    = r_is_edge;
        n_scan_cnt   = r_scan_cnt;
        n_chk_vld    = r_chk_vld;
        n_pick       = r_pick;
        n_eidx       = r_eidx;
        n_eb_vld     = 1'b0;
        n_ec_vld     = 1'b0;
        n_edge_total = r_edge_total;
        n_overflow   = r_overflow;
        n_strobe     = 1'b0;
        n_result     = r_result;
        do_clear     = 1'b0;
        lbl_raddr    = r_lbl_addr;
        lbl_we       = 1'b0;
        lbl_waddr    = r_lbl_addr;
        lbl_wdata    = entry_cur;
        edge_raddr   = r_eidx[EDGE_IDX_W-1:0];
        edge_we      = 1'b0;
        edge_wdata   = {t_label'(i_cmd.edge_from), t_label'(i_cmd.edge_to)};

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd.action)
                        ACT_ADD_VERTEX: begin
                            lbl_raddr = t_label'(i_cmd.vertex_label);
                            n_is_edge = 1'b0;
                            n_state   = S_LBL_WR;
                        end
                        ACT_ADD_EDGE: begin
                            if (r_edge_total == EDGE_CNT_W'(MAX_EDGES)) begin
                                n_overflow = 1'b1;
                            end else begin
                                edge_we      = 1'b1;
                                n_edge_total = r_edge_total + 1'b1;
                                lbl_raddr    = t_label'(i_cmd.edge_to);
                                n_is_edge    = 1'b1;
                                n_state      = S_LBL_WR;
                            end
                        end
                        ACT_NEXT: begin
                            n_scan_cnt = '0;
                            n_chk_vld  = 1'b0;
                            n_state    = S_SCAN;
                        end
                        ACT_CLEAR: begin
                            do_clear     = 1'b1;
                            n_edge_total = '0;
                            n_overflow   = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LBL_WR: begin
                lbl_we            = 1'b1;
                lbl_wdata.present = 1'b1;
                if (r_is_edge && (entry_cur.deg != DEG_MAX)) begin
                    lbl_wdata.deg = entry_cur.deg + 1'b1;
                end
                n_state = S_IDLE;
            end
            S_SCAN: begin
                lbl_raddr  = r_scan_cnt;
                n_scan_cnt = r_scan_cnt + 1'b1;
                n_chk_vld  = 1'b1;
                if (r_chk_vld) begin
                    if (entry_cur.present && !entry_cur.finished && (entry_cur.deg == '0)) begin
                        lbl_we             = 1'b1;
                        lbl_wdata.finished = 1'b1;
                        n_pick             = r_lbl_addr;
                        if (r_lbl_addr == '0) begin
                            n_strobe = 1'b1;
                            n_result = '{source_label: '0, found: 1'b0,
                                         edge_overflow: r_overflow};
                            n_state  = S_IDLE;
                        end else begin
                            n_eidx  = '0;
                            n_state = S_EDGE;
                        end
                    end else if (r_lbl_addr == '1) begin
                        n_strobe = 1'b1;
                        n_result = '{source_label: '0, found: 1'b0,
                                     edge_overflow: r_overflow};
                        n_state  = S_IDLE;
                    end
                end
            end
            S_EDGE: begin
                if (edge_more) begin
                    n_eidx   = r_eidx + 1'b1;
                    n_eb_vld = 1'b1;
                end
                if (r_eb_vld && (edge_rdata.from_lbl == r_pick)) begin
                    lbl_raddr = edge_rdata.to_lbl;
                    n_ec_vld  = 1'b1;
                end
                if (r_ec_vld) begin
                    lbl_we = 1'b1;
                    if (entry_cur.deg != '0) begin
                        lbl_wdata.deg = entry_cur.deg - 1'b1;
                    end
                end
                if (!edge_more && !r_eb_vld && !r_ec_vld) begin
                    n_strobe = 1'b1;
                    n_result = '{source_label: 8'(r_pick), found: 1'b1,
                                 edge_overflow: r_overflow};
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (lbl_we) begin
            lbl_mem[lbl_waddr] <= lbl_wdata;
        end
        lbl_rdata <= lbl_mem[lbl_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            edge_mem[r_edge_total[EDGE_IDX_W-1:0]] <= edge_wdata;
        end
        edge_rdata <= edge_mem[edge_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_lbl_addr <= lbl_raddr;
        r_fwd_addr <= lbl_waddr;
        r_fwd_data <= lbl_wdata;
        r_scan_cnt <= n_scan_cnt;
        r_pick     <= n_pick;
        r_eidx     <= n_eidx;
        r_is_edge  <= n_is_edge;
        r_result   <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_chk_vld    <= 1'b0;
            r_eb_vld     <= 1'b0;
            r_ec_vld     <= 1'b0;
            r_edge_total <= '0;
            r_overflow   <= 1'b0;
            r_valid      <= '0;
            r_fwd_vld    <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_chk_vld    <= n_chk_vld;
            r_eb_vld     <= n_eb_vld;
            r_ec_vld     <= n_ec_vld;
            r_edge_total <= n_edge_total;
            r_overflow   <= n_overflow;
            r_fwd_vld    <= lbl_we;
            r_strobe     <= n_strobe;
            if (do_clear) begin
                r_valid <= '0;
            end else if (lbl_we) begin
                r_valid[lbl_waddr] <= 1'b1;
            end
        end
    end

    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a command in flight");

    a_found_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.found) |-> (o_result.source_label != '0))
        else $error("found source with label zero");

    a_missing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.found) |-> (o_result.source_label == '0))
        else $error("nonzero label without a source");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edge_total <= EDGE_CNT_W'(MAX_EDGES))
        else $error("edge count beyond the store");

    a_edge_pipe_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_eb_vld || r_ec_vld) |-> (r_state == S_EDGE))
        else $error("edge pipeline active outside the edge pass");

endmodule

`default_nettype wire
